// ===== rtl/dmac_pkg.sv =====
// Shared types and constants for the DMA dimension coalesce / address block.
// No dependencies; every other file refers to this package by scoped name.
package dmac_pkg;

    localparam int NUM_DIMS = 6;
    localparam int IDX_W    = $clog2(NUM_DIMS);
    localparam int CNT_W    = $clog2(NUM_DIMS + 1);

    localparam logic [IDX_W-1:0] LAST_DIM = IDX_W'(NUM_DIMS - 1);

    // front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream payload widths
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_FIELD_W = 3 + 32 + 32 + 64;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // one classified dimension item as handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        side;
        logic [63:0] base;
        logic [31:0] esz;
        logic [31:0] shape;
        logic [31:0] scaled;   // shape stride * element size
        logic [31:0] term;     // offset * address stride * element size
    } t_dim_item;

endpackage

// ===== rtl/dmac_front.sv =====
// Front end: accepts dimension beats, tracks the dimension number and holds
// the element size, and forms the scaled stride and address term (dmac_pkg).
module dmac_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_side,
    input  logic [63:0]                      i_base,
    input  logic [31:0]                      i_esz,
    input  logic [31:0]                      i_shape,
    input  logic [31:0]                      i_sstride,
    input  logic [31:0]                      i_offset,
    input  logic [31:0]                      i_astride,
    output logic                             o_push,
    input  logic                             i_push_ready,
    output dmac_pkg::t_dim_item              o_item
);

    typedef struct packed {
        logic        first;
        logic        last;
        logic        side;
        logic [63:0] base;
        logic [31:0] esz;
        logic [31:0] shape;
        logic [31:0] sstride;
        logic [31:0] offset;
        logic [31:0] astride;
    } t_stage1;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        side;
        logic [63:0] base;
        logic [31:0] esz;
        logic [31:0] shape;
        logic [31:0] scaled;
        logic [31:0] oa;
    } t_stage2;

    logic [dmac_pkg::IDX_W-1:0] r_dim_cnt;
    logic [31:0]                r_held_esz;
    logic                       r_s1_v, r_s2_v, r_s3_v;
    t_stage1                    r_s1;
    t_stage2                    r_s2;
    dmac_pkg::t_dim_item        r_s3;

    logic        load1, load2, load3, adv3;
    logic        first_dim;
    logic [31:0] esz_now;
    logic [31:0] scaled_mul;
    logic [31:0] oa_mul;
    logic [31:0] term_mul;

    assign adv3   = r_s3_v && i_push_ready;
    assign load3  = r_s2_v && (!r_s3_v || adv3);
    assign load2  = r_s1_v && (!r_s2_v || load3);
    assign o_ready = !r_s1_v || load2;
    assign load1  = i_valid && o_ready;

    assign first_dim = (r_dim_cnt == '0);
    assign esz_now   = first_dim ? i_esz : r_held_esz;

    assign scaled_mul = r_s1.sstride * r_s1.esz;
    assign oa_mul     = r_s1.offset * r_s1.astride;
    assign term_mul   = r_s2.oa * r_s2.esz;

    assign o_push = r_s3_v;
    assign o_item = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_cnt <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
        end else begin
            if (load1) begin
                r_dim_cnt <= (r_dim_cnt == dmac_pkg::LAST_DIM) ? '0 : r_dim_cnt + 1'b1;
                if (first_dim) begin
                    r_held_esz <= i_esz;
                end
                r_s1.first   <= first_dim;
                r_s1.last    <= (r_dim_cnt == dmac_pkg::LAST_DIM);
                r_s1.side    <= i_side;
                r_s1.base    <= i_base;
                r_s1.esz     <= esz_now;
                r_s1.shape   <= i_shape;
                r_s1.sstride <= i_sstride;
                r_s1.offset  <= i_offset;
                r_s1.astride <= i_astride;
            end
            if (load1) begin
                r_s1_v <= 1'b1;
            end else if (load2) begin
                r_s1_v <= 1'b0;
            end

            if (load2) begin
                r_s2.first  <= r_s1.first;
                r_s2.last   <= r_s1.last;
                r_s2.side   <= r_s1.side;
                r_s2.base   <= r_s1.base;
                r_s2.esz    <= r_s1.esz;
                r_s2.shape  <= r_s1.shape;
                r_s2.scaled <= scaled_mul;
                r_s2.oa     <= oa_mul;
            end
            if (load2) begin
                r_s2_v <= 1'b1;
            end else if (load3) begin
                r_s2_v <= 1'b0;
            end

            if (load3) begin
                r_s3.first  <= r_s2.first;
                r_s3.last   <= r_s2.last;
                r_s3.side   <= r_s2.side;
                r_s3.base   <= r_s2.base;
                r_s3.esz    <= r_s2.esz;
                r_s3.shape  <= r_s2.shape;
                r_s3.scaled <= r_s2.scaled;
                r_s3.term   <= term_mul;
            end
            if (load3) begin
                r_s3_v <= 1'b1;
            end else if (adv3) begin
                r_s3_v <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/dmac_fifo.sv =====
// Short queue of classified dimension items between front and back.
// Uses dmac_pkg for the item type and depth.
module dmac_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_push_ready,
    input  dmac_pkg::t_dim_item i_item,
    output logic                o_valid,
    input  logic                i_pop,
    output dmac_pkg::t_dim_item o_item
);

    dmac_pkg::t_dim_item         r_mem [dmac_pkg::QDEPTH];
    logic [dmac_pkg::QPTR_W-1:0] r_wr;
    logic [dmac_pkg::QPTR_W-1:0] r_rd;
    logic [dmac_pkg::QCNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_push_ready = (r_cnt != dmac_pkg::QCNT_W'(dmac_pkg::QDEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/dmac_back.sv =====
// Back end: merges leading contiguous dimensions, fills the reduced table,
// sums the start address and emits the descriptor entries (dmac_pkg).
module dmac_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_pop,
    input  dmac_pkg::t_dim_item                  i_item,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_side,
    output logic [dmac_pkg::IDX_W-1:0]           o_index,
    output logic [31:0]                          o_size,
    output logic [31:0]                          o_stride,
    output logic [63:0]                          o_addr,
    output logic                                 o_last
);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    t_state                     r_state, n_state;
    logic [31:0]                r_contig, n_contig;
    logic                       r_brk, n_brk;
    logic [dmac_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]                r_shape  [dmac_pkg::NUM_DIMS];
    logic [31:0]                n_shape  [dmac_pkg::NUM_DIMS];
    logic [31:0]                r_stride [dmac_pkg::NUM_DIMS];
    logic [31:0]                n_stride [dmac_pkg::NUM_DIMS];
    logic [63:0]                r_addr, n_addr;
    logic                       r_side, n_side;
    logic [dmac_pkg::IDX_W-1:0] r_k, n_k;
    logic                       r_out_v, n_out_v;
    logic                       r_o_side, n_o_side;
    logic [dmac_pkg::IDX_W-1:0] r_o_index, n_o_index;
    logic [31:0]                r_o_size, n_o_size;
    logic [31:0]                r_o_stride, n_o_stride;
    logic [63:0]                r_o_addr, n_o_addr;
    logic                       r_o_last, n_o_last;

    logic                       pop;
    logic                       out_free;
    logic [31:0]                base_contig;
    logic                       base_brk;
    logic [dmac_pkg::CNT_W-1:0] base_cnt;
    logic [31:0]                contig_prod;
    logic [31:0]                k_shape;

    assign pop      = (r_state == ST_COLLECT) && i_valid;
    assign o_pop    = pop;
    assign out_free = !r_out_v || i_ready;

    assign base_contig = i_item.first ? i_item.esz : r_contig;
    assign base_brk    = i_item.first ? 1'b0 : r_brk;
    assign base_cnt    = i_item.first ? '0 : r_cnt;
    assign contig_prod = base_contig * i_item.shape;
    assign k_shape     = r_shape[r_k];

    always_comb begin
        n_state    = r_state;
        n_contig   = r_contig;
        n_brk      = r_brk;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        n_side     = r_side;
        n_k        = r_k;
        n_out_v    = r_out_v;
        n_o_side   = r_o_side;
        n_o_index  = r_o_index;
        n_o_size   = r_o_size;
        n_o_stride = r_o_stride;
        n_o_addr   = r_o_addr;
        n_o_last   = r_o_last;
        for (int i = 0; i < dmac_pkg::NUM_DIMS; i++) begin
            n_shape[i]  = r_shape[i];
            n_stride[i] = r_stride[i];
        end

        if (pop) begin
            // a tensor's first dimension restarts the reduced table
            if (i_item.first) begin
                for (int i = 0; i < dmac_pkg::NUM_DIMS; i++) begin
                    n_shape[i]  = 32'd1;
                    n_stride[i] = 32'd0;
                end
                n_side = i_item.side;
            end
            n_contig = base_contig;
            n_brk    = base_brk;
            n_cnt    = base_cnt;
            if (base_cnt < dmac_pkg::CNT_W'(dmac_pkg::NUM_DIMS)) begin
                if (base_brk) begin
                    for (int i = 0; i < dmac_pkg::NUM_DIMS; i++) begin
                        if (base_cnt == dmac_pkg::CNT_W'(i)) begin
                            n_shape[i]  = i_item.shape;
                            n_stride[i] = i_item.scaled;
                        end
                    end
                    n_cnt = base_cnt + 1'b1;
                end else if (i_item.scaled != base_contig) begin
                    // first break: count is still zero here
                    n_shape[0]  = base_contig;
                    n_stride[0] = i_item.esz;
                    n_shape[1]  = i_item.shape;
                    n_stride[1] = i_item.scaled;
                    n_cnt       = dmac_pkg::CNT_W'(2);
                    n_brk       = 1'b1;
                end else begin
                    n_contig = contig_prod;
                end
            end
            n_addr = (i_item.first ? i_item.base : r_addr) + {32'd0, i_item.term};
            if (i_item.last) begin
                if (n_cnt == '0) begin
                    n_shape[0]  = n_contig;
                    n_stride[0] = i_item.esz;
                end
                n_state = ST_EMIT;
                n_k     = '0;
            end
        end

        if (r_state == ST_EMIT && out_free) begin
            n_out_v    = 1'b1;
            n_o_side   = r_side;
            n_o_index  = r_k;
            n_o_stride = r_stride[r_k];
            n_o_addr   = r_addr;
            n_o_last   = (r_k == dmac_pkg::LAST_DIM);
            if (r_k == '0) begin
                n_o_size = k_shape;
            end else begin
                n_o_size = (k_shape == '0) ? '0 : k_shape - 1'b1;
            end
            if (r_k == dmac_pkg::LAST_DIM) begin
                n_state = ST_COLLECT;
            end else begin
                n_k = r_k + 1'b1;
            end
        end else if (i_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_brk   <= 1'b0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_contig   <= n_contig;
            r_brk      <= n_brk;
            r_cnt      <= n_cnt;
            r_addr     <= n_addr;
            r_side     <= n_side;
            r_k        <= n_k;
            r_out_v    <= n_out_v;
            r_o_side   <= n_o_side;
            r_o_index  <= n_o_index;
            r_o_size   <= n_o_size;
            r_o_stride <= n_o_stride;
            r_o_addr   <= n_o_addr;
            r_o_last   <= n_o_last;
            for (int i = 0; i < dmac_pkg::NUM_DIMS; i++) begin
                r_shape[i]  <= n_shape[i];
                r_stride[i] <= n_stride[i];
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_side   = r_o_side;
    assign o_index  = r_o_index;
    assign o_size   = r_o_size;
    assign o_stride = r_o_stride;
    assign o_addr   = r_o_addr;
    assign o_last   = r_o_last;

endmodule

// ===== rtl/dma_dim_coalesce_and_address_top.sv =====
// Top level of the DMA dimension coalesce and start address block.
// Instantiates dmac_front, dmac_fifo and dmac_back; types from dmac_pkg.
//
//  channel   direction  beat contents
//  s_axis    in         one dimension item, innermost first, six per tensor
//  m_axis    out        one descriptor entry, six per tensor, tlast on entry 5
//
// The front is a three-stage multiply pipeline that takes one beat per cycle, unless
// the queue holds it back, into a four-deep queue. The back takes one queued item per
// cycle while collecting, then loads the output register with each of the NUM_DIMS
// entries in turn as it frees, and takes no new item until the last entry is loaded.
// Synchronous active-low reset clears all control state; no clearing pass is needed.
// Either side may stall at any time; the queue and output register absorb it.
module dma_dim_coalesce_and_address_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // base_address[63:0], element_size[95:64], dim_shape[127:96],
    // dim_shape_stride[159:128], tile_offset[191:160], address_stride[223:192]
    input  logic [dmac_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // is_destination[0]
    input  logic [0:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // entry_index[2:0], entry_size[34:3], entry_stride[66:35],
    // start_address[130:67], zero pad above
    output logic [dmac_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // side_flag[0]
    output logic [0:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    logic                       q_push, q_push_ready, q_valid, q_pop;
    dmac_pkg::t_dim_item        q_in_item, q_out_item;
    logic                       out_side;
    logic [dmac_pkg::IDX_W-1:0] out_index;
    logic [31:0]                out_size, out_stride;
    logic [63:0]                out_addr;
    logic [2:0]                 out_index3;

    dmac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_side       (i_s_axis_tuser[0]),
        .i_base       (i_s_axis_tdata[63:0]),
        .i_esz        (i_s_axis_tdata[95:64]),
        .i_shape      (i_s_axis_tdata[127:96]),
        .i_sstride    (i_s_axis_tdata[159:128]),
        .i_offset     (i_s_axis_tdata[191:160]),
        .i_astride    (i_s_axis_tdata[223:192]),
        .o_push       (q_push),
        .i_push_ready (q_push_ready),
        .o_item       (q_in_item)
    );

    dmac_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_push_ready (q_push_ready),
        .i_item       (q_in_item),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_item       (q_out_item)
    );

    dmac_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_out_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_side   (out_side),
        .o_index  (out_index),
        .o_size   (out_size),
        .o_stride (out_stride),
        .o_addr   (out_addr),
        .o_last   (o_m_axis_tlast)
    );

    assign out_index3     = 3'(out_index);
    assign o_m_axis_tuser = out_side;
    assign o_m_axis_tdata = dmac_pkg::OUT_TDATA_W'({out_addr, out_stride, out_size, out_index3});

    // tlast marks exactly the final entry
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (out_index == dmac_pkg::LAST_DIM)))
        else $error("tlast does not match entry index");

    // a run ends and the next starts at entry 0
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> (!o_m_axis_tvalid || out_index == '0))
        else $error("new run does not start at entry 0");

    // entries of a run follow back to back in order
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast)
        |=> (o_m_axis_tvalid && out_index == $past(out_index) + 1'b1))
        else $error("entry index out of sequence");

endmodule
